// ----- rtl/dual_shadow_call_stack_core_assert.svh -----
// Assertion macros for the shadow call stack.
`ifndef DUAL_SHADOW_CALL_STACK_CORE_ASSERT_SVH
`define DUAL_SHADOW_CALL_STACK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DSCS_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("dscs assertion failed");
`define DSCS_ASSERT_NEXT(label, clk_sig, rst_sig, pre, post) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) pre |=> post) \
        else $error("dscs assertion failed");
`else
`define DSCS_ASSERT(label, clk_sig, rst_sig, prop)
`define DSCS_ASSERT_NEXT(label, clk_sig, rst_sig, pre, post)
`endif
`endif

// ----- rtl/dscs_pkg.sv -----
package dscs_pkg;
    localparam int STACK_FRAMES_DEF   = 256;
    localparam int SNAPSHOT_DEPTH_DEF = 64;

    localparam logic [2:0] KIND_CALL   = 3'd0;
    localparam logic [2:0] KIND_RTS    = 3'd1;
    localparam logic [2:0] KIND_RTE    = 3'd2;
    localparam logic [2:0] KIND_EXC    = 3'd3;
    localparam logic [2:0] KIND_SAMPLE = 3'd4;

    // per-chain command, broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH,    // shift toward the bottom end, new value at top
        CMD_ROTATE,  // circular shift: bottom moves up, top wraps to bottom
        CMD_CLEAR,
        CMD_POP      // shift toward the top, bottom cell empties
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FIX,
        ST_LEAF,
        ST_EMIT_A,
        ST_ALIGN,
        ST_EMIT_U
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] data;
    } chain_ctl_t;
endpackage

// ----- rtl/dscs_cell.sv -----
// One stack slot: valid bit plus address, linked to both neighbors.
module dscs_cell
    import dscs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        up_valid,
    input  logic [31:0] up_addr,
    input  logic        dn_valid,
    input  logic [31:0] dn_addr,
    output logic        valid,
    output logic [31:0] addr
);
    logic        valid_reg;
    logic [31:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd)
                CMD_PUSH:            valid_reg <= up_valid;
                CMD_ROTATE, CMD_POP: valid_reg <= dn_valid;
                CMD_CLEAR:           valid_reg <= 1'b0;
                default:             valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_PUSH:            addr_reg <= up_addr;
            CMD_ROTATE, CMD_POP: addr_reg <= dn_addr;
            default:             addr_reg <= addr_reg;
        endcase
    end

    assign valid = valid_reg;
    assign addr  = addr_reg;
endmodule

// ----- rtl/dscs_chain.sv -----
// Row of cells; cell 0 is the stack top. Rotation walks entries past the top.
module dscs_chain
    import dscs_pkg::*;
#(
    parameter int STACK_FRAMES = STACK_FRAMES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctl_t  ctl,
    output logic        top_valid,
    output logic [31:0] top_addr,
    output logic        next_valid
);
    logic        v   [STACK_FRAMES];
    logic [31:0] a   [STACK_FRAMES];
    logic        uv  [STACK_FRAMES];
    logic [31:0] ua  [STACK_FRAMES];
    logic        dv  [STACK_FRAMES];
    logic [31:0] da  [STACK_FRAMES];

    // push: new value enters top; rotate: top wraps to bottom; pop: bottom empties
    assign uv[0] = 1'b1;
    assign ua[0] = ctl.data;
    assign dv[STACK_FRAMES-1] = (ctl.cmd == CMD_ROTATE) ? v[0] : 1'b0;
    assign da[STACK_FRAMES-1] = a[0];

    for (genvar g = 0; g < STACK_FRAMES; g++)
    begin : g_cell
        if (g > 0)
        begin : g_link
            assign uv[g] = v[g-1];
            assign ua[g] = a[g-1];
        end
        if (g < STACK_FRAMES - 1)
        begin : g_back
            assign dv[g] = v[g+1];
            assign da[g] = a[g+1];
        end
        dscs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (ctl.cmd),
            .up_valid (uv[g]),
            .up_addr  (ua[g]),
            .dn_valid (dv[g]),
            .dn_addr  (da[g]),
            .valid    (v[g]),
            .addr     (a[g])
        );
    end

    assign top_valid  = v[0];
    assign top_addr   = a[0];
    assign next_valid = v[1];
endmodule

// ----- rtl/dual_shadow_call_stack_core.sv -----
// Call, exception and unused kinds complete on acceptance; a sample passes the leaf state,
// which registers its leaf beat, then offers at most one frame per cycle.
// A return rotates its ring once to find a match, then pops down to and including it.
// A sample emits the leaf, then, if frames follow, walks the active ring and in supervisor
// mode the user ring; stalls hold it. One item at a time: input is taken only in idle.
// Reset (rst_n, async low) empties both stacks by clearing every cell's valid bit.
module dual_shadow_call_stack_core
    import dscs_pkg::*;
#(
    parameter int STACK_FRAMES   = STACK_FRAMES_DEF,
    parameter int SNAPSHOT_DEPTH = SNAPSHOT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic        supervisor,
    input  logic [31:0] return_address,
    input  logic [31:0] sample_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] frame_address,
    output logic [5:0]  frame_position,
    output logic        last_frame
);
`include "dual_shadow_call_stack_core_assert.svh"

    localparam int CW = $clog2(STACK_FRAMES + 1);

    // Each stack is a ring of cells, top at cell 0; depth is the count of valid
    // cells, always contiguous from the top. Pushes shift down and the oldest
    // falls off the bottom. A rotation moves every entry up one cell with the
    // top wrapping to the bottom, so the top shows entries in top-down order and
    // STACK_FRAMES rotations restore the ring.
    // Pop-to: one full rotation finds the first match from the top, then a pop
    // shift per dropped entry removes everything down to and including it.
    // Sample: leaf beat, then the active ring walked once, then the user ring in
    // supervisor mode; rotation always completes so order is kept.

    state_t      state_reg, state_next;
    logic        sel_sup_reg, sel_sup_next;   // stack under search/emit
    logic        emit_user_reg, emit_user_next;
    logic [31:0] ra_reg, ra_next;             // match address, or leaf pc on a sample
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] drop_reg, drop_next;
    logic        found_reg, found_next;
    logic [5:0]  pos_reg, pos_next;

    logic        ov_reg, ov_next;
    logic [31:0] oa_reg, oa_next;
    logic [5:0]  op_reg, op_next;
    logic        ol_reg, ol_next;

    chain_ctl_t  uctl, sctl;
    logic        u_tv, s_tv;
    logic [31:0] u_ta, s_ta;
    logic        u_nv, s_nv;
    logic        out_free;

    dscs_chain #(.STACK_FRAMES(STACK_FRAMES)) u_user (
        .clk(clk), .rst_n(rst_n), .ctl(uctl), .top_valid(u_tv), .top_addr(u_ta),
        .next_valid(u_nv));
    dscs_chain #(.STACK_FRAMES(STACK_FRAMES)) u_sup (
        .clk(clk), .rst_n(rst_n), .ctl(sctl), .top_valid(s_tv), .top_addr(s_ta),
        .next_valid(s_nv));

    assign out_free = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_sup_reg   <= sel_sup_next;
        emit_user_reg <= emit_user_next;
        ra_reg        <= ra_next;
        cnt_reg       <= cnt_next;
        drop_reg      <= drop_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        oa_reg        <= oa_next;
        op_reg        <= op_next;
        ol_reg        <= ol_next;
    end

    always_comb
    begin
        logic        tv;
        logic [31:0] ta;
        logic        etv;
        logic [31:0] eta;
        logic        enx;
        logic        emitting;
        logic        more;
        state_next     = state_reg;
        sel_sup_next   = sel_sup_reg;
        emit_user_next = emit_user_reg;
        ra_next        = ra_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        ov_next        = ov_reg && !out_ready;
        oa_next        = oa_reg;
        op_next        = op_reg;
        ol_next        = ol_reg;
        uctl           = '{cmd: CMD_HOLD, data: return_address};
        sctl           = '{cmd: CMD_HOLD, data: return_address};
        in_ready       = 1'b0;
        tv = sel_sup_reg ? s_tv : u_tv;
        ta = sel_sup_reg ? s_ta : u_ta;
        etv = (state_reg == ST_EMIT_U) ? u_tv : tv;
        eta = (state_reg == ST_EMIT_U) ? u_ta : ta;
        enx = (state_reg == ST_EMIT_A && sel_sup_reg) ? s_nv : u_nv;
        emitting = etv && !found_reg;
        more = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ra_next    = return_address;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    unique case (kind)
                        KIND_CALL:
                        begin
                            if (supervisor) sctl.cmd = CMD_PUSH;
                            else
                            begin
                                uctl.cmd = CMD_PUSH;
                                sctl.cmd = CMD_CLEAR;
                            end
                        end
                        KIND_RTS:
                        begin
                            sel_sup_next = supervisor;
                            if (!supervisor) sctl.cmd = CMD_CLEAR;
                            state_next = ST_SEARCH;
                        end
                        KIND_RTE:
                        begin
                            sel_sup_next = 1'b1;
                            state_next   = ST_SEARCH;
                        end
                        KIND_EXC: sctl.cmd = CMD_PUSH;
                        KIND_SAMPLE:
                        begin
                            sel_sup_next   = supervisor;
                            emit_user_next = supervisor;
                            ra_next        = sample_pc;
                            state_next     = ST_LEAF;
                        end
                        default: ;
                    endcase
                end
            end
            // rotate once; remember how many entries sit down to the topmost match
            ST_SEARCH:
            begin
                if (sel_sup_reg) sctl.cmd = CMD_ROTATE;
                else uctl.cmd = CMD_ROTATE;
                if (tv && ta == ra_reg && !found_reg)
                begin
                    found_next = 1'b1;
                    drop_next  = cnt_reg + CW'(1);
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(STACK_FRAMES - 1))
                begin
                    cnt_next   = '0;
                    state_next = found_next ? ST_FIX : ST_IDLE;
                end
            end
            // pop one entry per cycle until the match is gone
            ST_FIX:
            begin
                if (sel_sup_reg) sctl.cmd = CMD_POP;
                else uctl.cmd = CMD_POP;
                drop_next = drop_reg - CW'(1);
                if (drop_reg == CW'(1))
                    state_next = ST_IDLE;
            end
            ST_LEAF:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    oa_next  = ra_reg;
                    op_next  = '0;
                    pos_next = '0;
                    ol_next  = !(tv || (emit_user_reg && u_tv)) || SNAPSHOT_DEPTH == 1;
                    cnt_next = '0;
                    state_next = ol_next ? ST_IDLE : ST_EMIT_A;
                    if (!ol_next && !tv) state_next = ST_ALIGN;
                end
            end
            // walk the ring: emit valid tops until cap, always finish rotation
            ST_EMIT_A, ST_EMIT_U:
            begin
                if (!emitting || out_free)
                begin
                    if (state_reg == ST_EMIT_U || !sel_sup_reg) uctl.cmd = CMD_ROTATE;
                    else sctl.cmd = CMD_ROTATE;
                    if (emitting)
                    begin
                        ov_next  = 1'b1;
                        oa_next  = eta;
                        op_next  = pos_reg + 6'd1;
                        pos_next = pos_reg + 6'd1;
                        // last if capped or nothing valid follows in this ring or next
                        more = (cnt_reg != CW'(STACK_FRAMES - 1)) && enx;
                        if (state_reg == ST_EMIT_A && sel_sup_reg)
                            more = more || u_tv;
                        ol_next = (pos_reg + 6'd1 == 6'(SNAPSHOT_DEPTH - 1)) || !more;
                        if (ol_next) found_next = 1'b1;
                    end
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(STACK_FRAMES - 1))
                    begin
                        cnt_next = '0;
                        if (state_reg == ST_EMIT_A && emit_user_reg && !found_next)
                            state_next = ST_EMIT_U;
                        else
                            state_next = ST_IDLE;
                        found_next = (state_next == ST_EMIT_U) ? 1'b0 : found_next;
                    end
                end
            end
            ST_ALIGN:
            begin
                state_next = ST_EMIT_U;
                found_next = 1'b0;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid      = ov_reg;
    assign frame_address  = oa_reg;
    assign frame_position = op_reg;
    assign last_frame     = ol_reg;

    `DSCS_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_reg == ST_IDLE)
    `DSCS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(frame_address))
    `DSCS_ASSERT(a_cap, clk, rst_n,
        out_valid |-> frame_position <= 6'(SNAPSHOT_DEPTH - 1))
endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import dscs_pkg::*;

    localparam int FRAMES = 256;
    localparam int SNAP   = 64;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [31:0] addr;
        logic [5:0]  pos;
        logic        last;
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic        supervisor;
    logic [31:0] return_address;
    logic [31:0] sample_pc;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] frame_address;
    logic [5:0]  frame_position;
    logic        last_frame;

    // shadow copy of both stacks, index 0 is the oldest entry
    logic [31:0] usr_stk [FRAMES];
    logic [31:0] sup_stk [FRAMES];
    int          usr_lvl;
    int          sup_lvl;

    frame_t      frame_q[$];
    int          err_cnt = 0;
    longint      cyc = 0;

    dual_shadow_call_stack_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .supervisor     (supervisor),
        .return_address (return_address),
        .sample_pc      (sample_pc),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_address  (frame_address),
        .frame_position (frame_position),
        .last_frame     (last_frame)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // push with oldest-entry drop on overflow
    task automatic push_usr(logic [31:0] a);
        int i;
        if (usr_lvl >= FRAMES)
        begin
            for (i = 0; i < FRAMES - 1; i++)
                usr_stk[i] = usr_stk[i + 1];
            usr_lvl = FRAMES - 1;
        end
        usr_stk[usr_lvl] = a;
        usr_lvl++;
    endtask

    task automatic push_sup(logic [31:0] a);
        int i;
        if (sup_lvl >= FRAMES)
        begin
            for (i = 0; i < FRAMES - 1; i++)
                sup_stk[i] = sup_stk[i + 1];
            sup_lvl = FRAMES - 1;
        end
        sup_stk[sup_lvl] = a;
        sup_lvl++;
    endtask

    // pop down to and including the nearest match from the top; no match, no change
    task automatic unwind_usr(logic [31:0] a);
        int i;
        for (i = usr_lvl - 1; i >= 0; i--)
            if (usr_stk[i] == a)
            begin
                usr_lvl = i;
                return;
            end
    endtask

    task automatic unwind_sup(logic [31:0] a);
        int i;
        for (i = sup_lvl - 1; i >= 0; i--)
            if (sup_stk[i] == a)
            begin
                sup_lvl = i;
                return;
            end
    endtask

    // update shadow state and queue the snapshot frames a beat produces
    task automatic track_event(logic [2:0] k, logic s, logic [31:0] ra, logic [31:0] pc);
        logic [31:0] snap [$];
        frame_t      f;
        int          i;
        case (k)
            KIND_CALL:
                if (s)
                    push_sup(ra);
                else
                begin
                    push_usr(ra);
                    sup_lvl = 0;
                end
            KIND_RTS:
                if (s)
                    unwind_sup(ra);
                else
                begin
                    unwind_usr(ra);
                    sup_lvl = 0;
                end
            KIND_RTE:
                unwind_sup(ra);
            KIND_EXC:
                push_sup(ra);
            KIND_SAMPLE:
            begin
                snap = {snap, pc};
                if (s)
                begin
                    for (i = sup_lvl; i > 0 && snap.size() < SNAP; i--)
                        snap = {snap, sup_stk[i - 1]};
                    for (i = usr_lvl; i > 0 && snap.size() < SNAP; i--)
                        snap = {snap, usr_stk[i - 1]};
                end
                else
                    for (i = usr_lvl; i > 0 && snap.size() < SNAP; i--)
                        snap = {snap, usr_stk[i - 1]};
                for (i = 0; i < snap.size(); i++)
                begin
                    f.addr = snap[i];
                    f.pos  = i[5:0];
                    f.last = (i == snap.size() - 1);
                    frame_q = {frame_q, f};
                end
            end
            default: ;  // unused codes are ignored
        endcase
    endtask

    // one beat on the input channel, driven at the falling edge
    task automatic send_event(logic [2:0] k, logic s, logic [31:0] ra, logic [31:0] pc);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        supervisor     <= s;
        return_address <= ra;
        sample_pc      <= pc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_event(k, s, ra, pc);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(negedge clk);
        repeat (2 * FRAMES + 10) @(negedge clk);
    endtask

    // output side: random back-pressure
    initial
    begin
        int     g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g != 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // compare each accepted frame
    always @(posedge clk)
    begin
        frame_t f;
        cyc <= cyc + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_q.size() == 0)
            begin
                $error("unexpected frame addr=%h pos=%0d", frame_address, frame_position);
                err_cnt++;
            end
            else
            begin
                f = frame_q.pop_front();
                if (frame_address !== f.addr)
                begin
                    $error("frame_address exp %h got %h", f.addr, frame_address);
                    err_cnt++;
                end
                if (frame_position !== f.pos)
                begin
                    $error("frame_position exp %0d got %0d", f.pos, frame_position);
                    err_cnt++;
                end
                if (last_frame !== f.last)
                begin
                    $error("last_frame exp %0d got %0d", f.last, last_frame);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
        if (cyc > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end

    task automatic test_directed();
        send_event(KIND_SAMPLE, 1'b0, 32'h0, 32'h0);           // empty stacks, leaf only
        send_event(KIND_SAMPLE, 1'b1, 32'h0, 32'hFFFF_FFFF);
        send_event(KIND_CALL, 1'b0, 32'hFFFF_FFFF, 32'h0);
        send_event(KIND_CALL, 1'b0, 32'h0000_0000, 32'h0);
        send_event(KIND_CALL, 1'b1, 32'hAAAA_5555, 32'h0);     // supervisor push only
        send_event(KIND_EXC, 1'b0, 32'h5555_AAAA, 32'h0);      // exception ignores mode
        send_event(KIND_SAMPLE, 1'b1, 32'h0, 32'h1234_5678);
        send_event(KIND_SAMPLE, 1'b0, 32'h0, 32'h8765_4321);
        send_event(KIND_RTE, 1'b0, 32'hAAAA_5555, 32'h0);      // rte uses supervisor stack
        send_event(KIND_SAMPLE, 1'b1, 32'h0, 32'h1);
        send_event(KIND_RTS, 1'b1, 32'hDEAD_BEEF, 32'h0);      // no match
        send_event(KIND_EXC, 1'b1, 32'h0000_0001, 32'h0);
        send_event(KIND_RTS, 1'b0, 32'h1111_1111, 32'h0);      // user miss, still clears sup
        send_event(KIND_SAMPLE, 1'b1, 32'h0, 32'h2);
        send_event(3'd5, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unused codes
        send_event(3'd6, 1'b1, 32'h0, 32'h0);
        send_event(3'd7, 1'b1, 32'hFFFF_FFFF, 32'h0);
        send_event(KIND_RTS, 1'b0, 32'h0000_0000, 32'h0);
        send_event(KIND_SAMPLE, 1'b0, 32'h0, 32'h3);
        send_event(KIND_EXC, 1'b1, 32'h7, 32'h0);
        send_event(KIND_CALL, 1'b0, 32'h8, 32'h0);             // user call empties sup
        send_event(KIND_SAMPLE, 1'b1, 32'h0, 32'h4);
        wait_drained();
    endtask

    // overflow the user stack so the oldest entries drop, then sample the cap
    task automatic test_overflow();
        int i;
        for (i = 0; i < FRAMES + 2; i++)
            send_event(KIND_CALL, 1'b0, $urandom, 32'h0);
        send_event(KIND_EXC, 1'b0, $urandom, 32'h0);
        send_event(KIND_SAMPLE, 1'b1, 32'h0, $urandom);
        send_event(KIND_SAMPLE, 1'b0, 32'h0, $urandom);
        send_event(KIND_RTS, 1'b0, usr_stk[0], 32'h0);           // pop to the bottom
        send_event(KIND_SAMPLE, 1'b0, 32'h0, $urandom);
        wait_drained();
    endtask

    // nested call/return traffic from a small address pool so returns match
    task automatic test_random();
        int          n;
        int          r;
        logic [2:0]  k;
        logic        s;
        logic [31:0] ra;
        for (n = 0; n < 85; n++)
        begin
            r = $urandom_range(0, 99);
            s = 1'($urandom_range(0, 1));
            if (r < 30)
                k = KIND_CALL;
            else if (r < 50)
                k = KIND_RTS;
            else if (r < 60)
                k = KIND_RTE;
            else if (r < 72)
                k = KIND_EXC;
            else if (r < 95)
                k = KIND_SAMPLE;
            else
                k = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 9) < 8)
                ra = 32'h1000 + 4 * $urandom_range(0, 15);
            else
                ra = $urandom;
            // bias returns toward a live entry
            if (k == KIND_RTS && !s && usr_lvl > 0 && $urandom_range(0, 1))
                ra = usr_stk[$urandom_range(0, usr_lvl - 1)];
            if ((k == KIND_RTE || (k == KIND_RTS && s)) && sup_lvl > 0
                && $urandom_range(0, 1))
                ra = sup_stk[$urandom_range(0, sup_lvl - 1)];
            send_event(k, s, ra, $urandom);
            if (n == 42)
            begin
                in_valid <= 1'b0;
                while (frame_q.size() != 0)
                    @(negedge clk);                              // hold until drained
            end
        end
        wait_drained();
    endtask

    initial
    begin
        usr_lvl        = 0;
        sup_lvl        = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_CALL;
        supervisor     = 1'b0;
        return_address = 32'h0;
        sample_pc      = 32'h0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_overflow();
        test_random();
        if (err_cnt == 0 && frame_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dscs_pkg.sv
rtl/dscs_cell.sv
rtl/dscs_chain.sv
rtl/dual_shadow_call_stack_core.sv
test/tb_top.sv
